@@ hdl/assert_macros.svh @@
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define KH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("khist check failed");

// clocked assertion that also holds during reset
`define KH_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("khist check failed");

`endif

@@ hdl/khist_pkg.sv @@
// package: beat types, table sizes, sequencer states and bucket function
`timescale 1ns / 1ps

package khist_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int FILL_W        = IDX_W + 1;
    localparam int KB_SHIFT      = 10;
    localparam int QUOT_W        = 32 - KB_SHIFT;

    typedef struct packed {
        logic [31:0] proc_id;
        logic [31:0] user_id;
        logic [63:0] name_low;
        logic [63:0] name_high;
        logic [31:0] request_bytes;
    } t_in_beat;

    typedef struct packed {
        logic [4:0]  size_bucket;
        logic [63:0] new_count;
        logic        was_inserted;
        logic        was_dropped;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] proc_id;
        logic [31:0] user_id;
        logic [63:0] name_low;
        logic [63:0] name_high;
        logic [4:0]  bucket;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [63:0] count;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_MISS,
        ST_DONE
    } t_state;

    // floor log2 of the kilobyte count, zero for a count of zero
    function automatic logic [4:0] size_bucket_of(input logic [31:0] len);
        logic [QUOT_W-1:0] q;
        logic [4:0]        b;
        q = len[31:KB_SHIFT];
        b = '0;
        for (int i = 1; i < QUOT_W; i++) begin
            if (q[i]) begin
                b = 5'(i);
            end
        end
        return b;
    endfunction

endpackage

@@ hdl/keyed_log2_size_histogram.sv @@
// top level: keyed log2 request-size histogram with output register
`timescale 1ns / 1ps

//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-------------------------------
//  in      | i_in_valid  | o_in_stall   | i_in_data  (t_in_beat)
//  out     | o_out_valid | i_out_stall  | o_out_data (t_out_beat)
//
//  each beat probes the filled entries in order, one entry per READ and CMP state pair,
//  until a key matches or all N filled entries (up to 1024) are probed; a miss then
//  inserts at the fill count or, with the table full, reports a drop
//  reset empties the table at once through the fill count, no clearing pass
//  a result beat sits in the output register, so the next input beat is
//  taken while it waits under stall

module keyed_log2_size_histogram (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  khist_pkg::t_in_beat   i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output khist_pkg::t_out_beat  o_out_data,
    input  logic                  i_out_stall
);

    logic                 res_valid;
    khist_pkg::t_out_beat res_data;
    logic                 res_take;

    logic                 r_out_valid, n_out_valid;
    khist_pkg::t_out_beat r_out_data, n_out_data;

    // probe sequencer and entry memory
    khist_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res_data  (res_data),
        .i_res_take  (res_take)
    );

    // output register takes a result when empty or being drained
    assign res_take = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (res_take) begin
            n_out_valid = res_valid;
            if (res_valid) begin
                n_out_data = res_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hdl/khist_table.sv @@
// entry memory with a linear probe sequencer
`timescale 1ns / 1ps

module khist_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  khist_pkg::t_in_beat   i_in_data,
    output logic                  o_in_stall,
    output logic                  o_res_valid,
    output khist_pkg::t_out_beat  o_res_data,
    input  logic                  i_res_take
);

    khist_pkg::t_entry r_mem [khist_pkg::TABLE_ENTRIES];
    khist_pkg::t_entry r_rdata;

    khist_pkg::t_state              r_state, n_state;
    khist_pkg::t_key                r_key, n_key;
    logic [khist_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [khist_pkg::FILL_W-1:0]   r_fill, n_fill;
    khist_pkg::t_out_beat           r_res, n_res;

    logic                           mem_re;
    logic                           mem_we;
    logic [khist_pkg::IDX_W-1:0]    mem_waddr;
    khist_pkg::t_entry              mem_wdata;
    logic [khist_pkg::FILL_W-1:0]   idx_next;
    logic [63:0]                    cnt_inc;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= khist_pkg::ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
        r_key <= n_key;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign idx_next = {1'b0, r_idx} + 1'b1;
    assign cnt_inc  = r_rdata.count + 64'd1;

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_res     = r_res;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = {r_key, 64'd1};
        case (r_state)
            khist_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_key.proc_id   = i_in_data.proc_id;
                    n_key.user_id   = i_in_data.user_id;
                    n_key.name_low  = i_in_data.name_low;
                    n_key.name_high = i_in_data.name_high;
                    n_key.bucket    = khist_pkg::size_bucket_of(i_in_data.request_bytes);
                    n_idx           = '0;
                    n_state = (r_fill == '0) ? khist_pkg::ST_MISS : khist_pkg::ST_READ;
                end
            end
            khist_pkg::ST_READ: begin
                mem_re  = 1'b1;
                n_state = khist_pkg::ST_CMP;
            end
            khist_pkg::ST_CMP: begin
                if (r_rdata.key == r_key) begin
                    mem_we    = 1'b1;
                    mem_wdata = {r_key, cnt_inc};
                    n_res     = {r_key.bucket, cnt_inc, 1'b0, 1'b0};
                    n_state   = khist_pkg::ST_DONE;
                end else if (idx_next == r_fill) begin
                    n_state = khist_pkg::ST_MISS;
                end else begin
                    n_idx   = idx_next[khist_pkg::IDX_W-1:0];
                    n_state = khist_pkg::ST_READ;
                end
            end
            khist_pkg::ST_MISS: begin
                if (r_fill == khist_pkg::FILL_W'(khist_pkg::TABLE_ENTRIES)) begin
                    n_res = {r_key.bucket, 64'd0, 1'b0, 1'b1};
                end else begin
                    // table fills in order, so the next free entry is the fill count
                    mem_we    = 1'b1;
                    mem_waddr = r_fill[khist_pkg::IDX_W-1:0];
                    n_fill    = r_fill + 1'b1;
                    n_res     = {r_key.bucket, 64'd1, 1'b1, 1'b0};
                end
                n_state = khist_pkg::ST_DONE;
            end
            khist_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = khist_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = khist_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != khist_pkg::ST_IDLE);
    assign o_res_valid = (r_state == khist_pkg::ST_DONE);
    assign o_res_data  = r_res;

endmodule

@@ hdl/khist_checker.sv @@
// port checker for the histogram top level, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module khist_port_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input khist_pkg::t_out_beat  o_out_data,
    input logic                  i_out_stall
);

    logic out_drop;
    logic out_insert;
    logic drop_ok;

    assign out_drop   = o_out_valid && o_out_data.was_dropped;
    assign out_insert = o_out_valid && o_out_data.was_inserted;
    assign drop_ok    = (o_out_data.new_count == 64'd0) && !o_out_data.was_inserted;

    `KH_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)
    `KH_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall)
    `KH_ASSERT(a_drop_empty, i_clk, i_rst_n, out_drop |-> drop_ok)
    `KH_ASSERT(a_insert_one, i_clk, i_rst_n, out_insert |-> o_out_data.new_count == 64'd1)
    `KH_ASSERT(a_bucket_range, i_clk, i_rst_n, o_out_valid |-> o_out_data.size_bucket <= 5'd21)

endmodule

bind keyed_log2_size_histogram khist_port_checker u_khist_port_checker (.*);

@@ verif/khist_checker.sv @@
// checker: watches both channels, predicts each result beat and compares it
`timescale 1ns / 1ps

module khist_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  khist_pkg::t_in_beat   i_in_data,
    input  logic                  i_in_stall,
    input  logic                  i_out_valid,
    input  khist_pkg::t_out_beat  i_out_data,
    input  logic                  i_out_stall,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_used_entries,
    output int                    o_drops
);

    khist_pkg::t_key      tbl_key   [khist_pkg::TABLE_ENTRIES];
    logic [63:0]          tbl_count [khist_pkg::TABLE_ENTRIES];
    int                   used_entries;
    int                   drops;
    int                   mismatches;
    int                   pending;
    khist_pkg::t_out_beat expected_results[$];

    assign o_mismatches   = mismatches;
    assign o_pending      = pending;
    assign o_used_entries = used_entries;
    assign o_drops        = drops;

    function automatic logic [4:0] kb_log2(input logic [31:0] len);
        logic [21:0] kb;
        logic [4:0]  b;
        kb = len[31:10];
        b  = '0;
        for (int i = 21; i >= 1; i--) begin
            if (kb[i] && b == '0) begin
                b = 5'(i);
            end
        end
        return b;
    endfunction

    // entries fill in order and are never freed, so the free slot is the fill count
    function automatic khist_pkg::t_out_beat count_event(input khist_pkg::t_in_beat ev);
        khist_pkg::t_key      k;
        khist_pkg::t_out_beat r;
        k.proc_id   = ev.proc_id;
        k.user_id   = ev.user_id;
        k.name_low  = ev.name_low;
        k.name_high = ev.name_high;
        k.bucket    = kb_log2(ev.request_bytes);
        r.size_bucket  = k.bucket;
        r.was_inserted = 1'b0;
        r.was_dropped  = 1'b0;
        for (int i = 0; i < used_entries; i++) begin
            if (tbl_key[i] == k) begin
                tbl_count[i] = tbl_count[i] + 64'd1;
                r.new_count  = tbl_count[i];
                return r;
            end
        end
        if (used_entries < khist_pkg::TABLE_ENTRIES) begin
            tbl_key[used_entries]   = k;
            tbl_count[used_entries] = 64'd1;
            used_entries++;
            r.new_count    = 64'd1;
            r.was_inserted = 1'b1;
        end else begin
            drops++;
            r.new_count   = '0;
            r.was_dropped = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        khist_pkg::t_out_beat want;
        if (!i_rst_n) begin
            used_entries = 0;
            drops        = 0;
            mismatches   <= 0;
            expected_results.delete();
            pending      = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(count_event(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result beat %p", i_out_data);
                    end
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.size_bucket !== i_out_data.size_bucket ||
                        want.new_count !== i_out_data.new_count ||
                        want.was_inserted !== i_out_data.was_inserted ||
                        want.was_dropped !== i_out_data.was_dropped) begin
                        if (mismatches < 10) begin
                            $display("result mismatch: expected %p, got %p",
                                     want, i_out_data);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending = expected_results.size();
        end
    end
endmodule

@@ verif/testbench.sv @@
// testbench top: stimulus for the keyed histogram and the final verdict
`timescale 1ns / 1ps

module testbench;

    // the limit allows for full-table events, which probe every entry, and for the fill
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int POOL_SIZE   = 48;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    khist_pkg::t_in_beat  in_data;
    logic                 in_stall;
    logic                 out_valid;
    khist_pkg::t_out_beat out_data;
    logic                 out_stall;

    int mismatches;
    int pending;
    int used_entries;
    int drops;
    int beats_sent;
    int cycles = 0;
    int out_hold;
    logic quiet;

    // small set of process/name tuples so most random events hit
    khist_pkg::t_in_beat key_pool[POOL_SIZE];

    keyed_log2_size_histogram u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    khist_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_data      (in_data),
        .i_in_stall     (in_stall),
        .i_out_valid    (out_valid),
        .i_out_data     (out_data),
        .i_out_stall    (out_stall),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_used_entries (used_entries),
        .o_drops        (drops)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle draw per beat; quiet stretches give back-to-back traffic
    function automatic int idle_draw();
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    // receiver: after taking each result beat, stall for a drawn hold before the next
    always @(posedge clk) begin
        int h;
        h = 0;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_hold  <= 0;
        end else if (out_hold > 0) begin
            out_hold  <= out_hold - 1;
            out_stall <= 1'b1;
        end else if (out_valid && !out_stall) begin
            h = idle_draw();
            out_hold  <= (h > 0) ? h - 1 : 0;
            out_stall <= (h > 0);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one beat: optional gap, then hold valid until the block takes it
    task automatic send_event(input khist_pkg::t_in_beat ev);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (in_stall);
        beats_sent++;
        quiet = ((beats_sent / 90) % 4) == 3;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    function automatic khist_pkg::t_in_beat random_event();
        khist_pkg::t_in_beat ev;
        ev.proc_id       = $urandom;
        ev.user_id       = $urandom;
        ev.name_low      = {$urandom, $urandom};
        ev.name_high     = {$urandom, $urandom};
        ev.request_bytes = $urandom;
        return ev;
    endfunction

    // pool key with a short length, bucket 0..2 only, keeps the table small
    function automatic khist_pkg::t_in_beat pool_event();
        khist_pkg::t_in_beat ev;
        ev = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        ev.request_bytes = $urandom_range(0, 8191);
        return ev;
    endfunction

    initial begin
        khist_pkg::t_in_beat ev;
        khist_pkg::t_in_beat base;
        int n;
        beats_sent = 0;
        quiet      = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = random_event();
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lengths at and around several bucket boundaries, all-zero and all-one keys
        base = key_pool[0];
        ev = '0;
        send_event(ev);                         // zero key, zero length
        send_event(ev);                         // hit on the same entry
        ev.request_bytes = 32'd1023;  send_event(ev);  // short length, still bucket 0
        ev.request_bytes = 32'd2047;  send_event(ev);
        ev.request_bytes = 32'd2048;  send_event(ev);  // first bucket 1
        ev.request_bytes = 32'd4095;  send_event(ev);
        ev.request_bytes = 32'd4096;  send_event(ev);
        ev.request_bytes = 32'h8000_0000; send_event(ev);
        ev.request_bytes = 32'hFFFF_FFFF; send_event(ev);  // top bucket
        ev.request_bytes = 32'h7FFF_FFFF; send_event(ev);
        ev = '1;
        send_event(ev);
        send_event(ev);
        ev.request_bytes = 32'd0;     send_event(ev);
        ev.proc_id = 32'd0;           send_event(ev);  // differs in process only
        ev.user_id = 32'd0;           send_event(ev);
        ev.name_low = 64'd0;          send_event(ev);
        ev.name_high = 64'd0;         send_event(ev);
        for (int b = 11; b <= 31; b += 4) begin
            ev = base;
            ev.request_bytes = 32'd1 << b;
            send_event(ev);
        end
        drain();

        // random: mostly repeating pool keys, some fully random events
        for (int i = 0; i < 1000; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                send_event(pool_event());
            end else begin
                send_event(random_event());
            end
        end
        drain();

        // fill the table with unique process ids, then run against a full table
        n = khist_pkg::TABLE_ENTRIES - used_entries;
        for (int i = 0; i < n; i++) begin
            ev = random_event();
            ev.proc_id = 32'hC000_0000 | i;
            send_event(ev);
        end
        drain();
        for (int i = 0; i < 160; i++) begin
            case ($urandom_range(0, 2))
                0: send_event(pool_event());
                1: send_event(random_event());
                default: begin
                    ev = '0;
                    send_event(ev);
                end
            endcase
        end
        drain();
        repeat (20) @(posedge clk);

        $display("sent %0d event beats, table ended with %0d entries", beats_sent,
                 used_entries);
        $display("covered bucket edges, hits, inserts and %0d drops on a full table",
                 drops);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
